>>> design/fsft_pkg.sv
// Shared types and constants for the flagged substring filter table.
// No dependencies.
`timescale 1ns / 1ps
package fsft_pkg;
    localparam int NUM_FILTERS_DEF = 16;
    localparam int MAX_LEN_DEF     = 256;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // Command handed from the front part to the back part.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] char_code;
        logic        last;
        logic [31:0] op_flags;
        logic [31:0] filter_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  resp_kind;
        logic        ok;
        logic [31:0] assigned_id;
    } resp_t;
endpackage

>>> design/flagged_substring_filter_table.sv
// Top level of the flagged substring filter table.
// Depends on fsft_pkg, fsft_front, fsft_back, fsft_ram.
// Query: after the last character the back part walks the entries until a hit
// or the last entry, comparing each character pair via ST_RD, ST_WAIT, ST_CMP.
// Throughput: one character per cycle when the back part is idle and its output
// register is free. Reset clears all valid bits.
`timescale 1ns / 1ps
module flagged_substring_filter_table #(
    parameter int NUM_FILTERS = fsft_pkg::NUM_FILTERS_DEF,
    parameter int MAX_LEN     = fsft_pkg::MAX_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // req_type[1:0], char_code[17:2], op_flags[49:18],
                                   // filter_id[81:50], zero fill
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // resp_kind[1:0], ok[2], assigned_id[34:3], zero fill
);
    fsft_pkg::cmd_t  in_cmd;
    fsft_pkg::cmd_t  q_cmd;
    fsft_pkg::resp_t resp;
    logic            q_valid;
    logic            q_ready;

    assign in_cmd = '{s_tdata[1:0], s_tdata[17:2], s_tlast, s_tdata[49:18], s_tdata[81:50]};

    fsft_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    fsft_back #(.NUM_FILTERS(NUM_FILTERS), .MAX_LEN(MAX_LEN)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_resp(resp)
    );

    assign m_tdata = {5'd0, resp.assigned_id, resp.ok, resp.resp_kind};
endmodule

>>> design/fsft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module fsft_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> design/fsft_front.sv
// Front part: accepts requests, lowercases query characters, drops type 3,
// and feeds a two-entry command queue. Depends on fsft_pkg.
`timescale 1ns / 1ps
module fsft_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fsft_pkg::cmd_t  in_cmd,
    output logic            q_valid,
    input  logic            q_ready,
    output fsft_pkg::cmd_t  q_cmd
);
    fsft_pkg::cmd_t  slot_reg [2];
    logic [1:0]      cnt_reg;
    logic            rd_ptr_reg;
    logic            wr_ptr_reg;
    fsft_pkg::cmd_t  cls;
    logic            push;
    logic            pop;
    logic            keep;

    // Classify: lowercase A-Z on query characters, discard unused request code.
    always_comb
    begin
        cls = in_cmd;
        if (in_cmd.req_type == fsft_pkg::REQ_QUERY && in_cmd.char_code >= 16'd65
            && in_cmd.char_code <= 16'd90)
        begin
            cls.char_code = in_cmd.char_code + 16'd32;
        end
    end

    assign keep     = (in_cmd.req_type != fsft_pkg::REQ_UNUSED);
    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_ptr_reg];
    assign pop      = q_valid && q_ready;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !pop) else $error("pop from empty queue");
    a_type3_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !keep |=> cnt_reg <= $past(cnt_reg)) else $error("unused code queued");
endmodule

>>> design/fsft_back.sv
// Back part: table storage, add/remove bookkeeping and the substring search
// sequencer, with a one-entry output register. Depends on fsft_pkg, fsft_ram.
`timescale 1ns / 1ps
module fsft_back #(
    parameter int NUM_FILTERS = fsft_pkg::NUM_FILTERS_DEF,
    parameter int MAX_LEN     = fsft_pkg::MAX_LEN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  fsft_pkg::cmd_t  q_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output fsft_pkg::resp_t out_resp
);
    localparam int SW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
    localparam int LW = $clog2(MAX_LEN);
    localparam int CW = LW + 1;
    localparam int PD = NUM_FILTERS * MAX_LEN;
    localparam int PW = $clog2(PD);
    localparam logic [CW-1:0] CAP = CW'(MAX_LEN - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ENTRY = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;

    logic [2:0]        state_reg;
    logic [NUM_FILTERS-1:0] valid_reg;
    logic [CW-1:0]     plen_reg  [NUM_FILTERS];
    logic [31:0]       flags_reg [NUM_FILTERS];
    logic [31:0]       ident_reg [NUM_FILTERS];
    logic              pend_reg;
    logic              full_reg;
    logic [SW-1:0]     pslot_reg;
    logic [CW-1:0]     pcnt_reg;
    logic [CW-1:0]     qcnt_reg;
    logic [CW-1:0]     qlen_reg;
    logic              qzero_reg;
    logic [31:0]       qmask_reg;
    logic [SW-1:0]     ent_reg;
    logic [CW-1:0]     plim_reg;
    logic [CW-1:0]     start_reg;
    logic [CW-1:0]     k_reg;
    logic              hit_reg;
    logic              out_valid_reg;
    fsft_pkg::resp_t   out_reg;

    logic              p_we;
    logic [PW-1:0]     p_waddr;
    logic [PW-1:0]     p_raddr;
    logic [15:0]       p_rdata;
    logic              q_we;
    logic [LW-1:0]     q_raddr;
    logic [15:0]       q_rdata;

    logic [SW-1:0]     free_slot;
    logic              free_found;
    logic [SW-1:0]     rm_slot;
    logic              rm_found;
    logic              take;
    logic              out_free;
    logic [CW-1:0]     ent_plen;
    logic              ent_eligible;

    fsft_ram #(.WIDTH(16), .DEPTH(PD)) u_pat (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(q_cmd.char_code),
        .raddr(p_raddr), .rdata(p_rdata)
    );
    fsft_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_qry (
        .clk(clk), .we(q_we), .waddr(qcnt_reg[LW-1:0]), .wdata(q_cmd.char_code),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // Lowest free slot and lowest slot holding the matching id.
    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        rm_slot    = '0;
        rm_found   = 1'b0;
        for (int i = NUM_FILTERS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot  = SW'(i);
                free_found = 1'b1;
            end
            if (valid_reg[i] && ident_reg[i] == q_cmd.filter_id)
            begin
                rm_slot  = SW'(i);
                rm_found = 1'b1;
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign q_ready  = (state_reg == ST_IDLE) && out_free;
    assign take     = q_valid && q_ready;
    assign out_valid = out_valid_reg;
    assign out_resp  = out_reg;

    // Memory write strobes.
    always_comb
    begin
        p_we    = 1'b0;
        q_we    = 1'b0;
        p_waddr = '0;
        if (take && q_cmd.req_type == fsft_pkg::REQ_ADD)
        begin
            if (!pend_reg)
            begin
                p_we    = free_found;
                p_waddr = PW'(free_slot) * PW'(MAX_LEN);
            end
            else
            begin
                p_we    = !full_reg && pcnt_reg < CAP;
                p_waddr = PW'(pslot_reg) * PW'(MAX_LEN) + PW'(pcnt_reg);
            end
        end
        if (take && q_cmd.req_type == fsft_pkg::REQ_QUERY)
        begin
            q_we = qcnt_reg < CAP;
        end
    end

    assign p_raddr = PW'(ent_reg) * PW'(MAX_LEN) + PW'(k_reg);
    assign q_raddr = LW'(start_reg + k_reg);
    assign ent_plen = plen_reg[ent_reg];
    assign ent_eligible = valid_reg[ent_reg] && ((flags_reg[ent_reg] & qmask_reg) != 32'd0);

    // Command sequencer and search walk.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            pend_reg      <= 1'b0;
            full_reg      <= 1'b0;
            pcnt_reg      <= '0;
            qcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_FILTERS; i++)
            begin
                plen_reg[i]  <= '0;
                flags_reg[i] <= '0;
                ident_reg[i] <= '0;
            end
        end
        else
        begin
            logic emit;
            emit = 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        case (q_cmd.req_type)
                            fsft_pkg::REQ_ADD:
                            begin
                                logic          fl;
                                logic [SW-1:0] sl;
                                logic [CW-1:0] c;
                                fl = pend_reg ? full_reg : !free_found;
                                sl = pend_reg ? pslot_reg : free_slot;
                                c  = pend_reg ? pcnt_reg : '0;
                                if (!fl && c < CAP)
                                begin
                                    c = c + CW'(1);
                                end
                                if (q_cmd.last)
                                begin
                                    if (!fl)
                                    begin
                                        plen_reg[sl]  <= c;
                                        flags_reg[sl] <= q_cmd.op_flags;
                                        ident_reg[sl] <= q_cmd.filter_id;
                                        valid_reg[sl] <= 1'b1;
                                    end
                                    pend_reg <= 1'b0;
                                    pcnt_reg <= '0;
                                    emit = 1'b1;
                                    out_reg <= '{fsft_pkg::KIND_ADD, !fl,
                                                 fl ? 32'd0 : q_cmd.filter_id};
                                end
                                else
                                begin
                                    pend_reg  <= 1'b1;
                                    full_reg  <= fl;
                                    pslot_reg <= sl;
                                    pcnt_reg  <= c;
                                end
                            end
                            fsft_pkg::REQ_QUERY:
                            begin
                                logic [CW-1:0] n;
                                logic          z;
                                n = qcnt_reg;
                                z = qzero_reg && qcnt_reg != '0;
                                if (qcnt_reg < CAP)
                                begin
                                    n = qcnt_reg + CW'(1);
                                    if (!z && q_cmd.char_code == 16'd0)
                                    begin
                                        qlen_reg <= qcnt_reg;
                                        z = 1'b1;
                                    end
                                end
                                if (!z)
                                begin
                                    qlen_reg <= n;
                                end
                                qzero_reg <= z;
                                if (q_cmd.last)
                                begin
                                    qcnt_reg  <= '0;
                                    qmask_reg <= q_cmd.op_flags;
                                    ent_reg   <= '0;
                                    hit_reg   <= 1'b0;
                                    state_reg <= ST_ENTRY;
                                end
                                else
                                begin
                                    qcnt_reg <= n;
                                end
                            end
                            fsft_pkg::REQ_REMOVE:
                            begin
                                if (rm_found)
                                begin
                                    valid_reg[rm_slot] <= 1'b0;
                                end
                                emit = 1'b1;
                                out_reg <= '{fsft_pkg::KIND_REMOVE, rm_found, 32'd0};
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                // Start one entry: zero stored length means empty pattern.
                ST_ENTRY:
                begin
                    if (hit_reg || !ent_eligible)
                    begin
                        if (hit_reg || int'(ent_reg) == NUM_FILTERS - 1)
                        begin
                            state_reg <= ST_IDLE;
                            emit = 1'b1;
                            out_reg <= '{fsft_pkg::KIND_QUERY, hit_reg, 32'd0};
                        end
                        else
                        begin
                            ent_reg <= ent_reg + SW'(1);
                        end
                    end
                    else if (ent_plen == '0)
                    begin
                        hit_reg <= 1'b1;
                    end
                    else
                    begin
                        plim_reg  <= ent_plen;
                        start_reg <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    state_reg <= ST_CMP;
                end
                // Compare one character pair.
                ST_CMP:
                begin
                    if (p_rdata == 16'd0 && k_reg == '0)
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= ST_ENTRY;
                    end
                    else if (p_rdata == 16'd0 ||
                             (start_reg + k_reg < qlen_reg && q_rdata == p_rdata
                              && k_reg + CW'(1) == plim_reg))
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= ST_ENTRY;
                    end
                    else if (start_reg + k_reg < qlen_reg && q_rdata == p_rdata)
                    begin
                        k_reg     <= k_reg + CW'(1);
                        state_reg <= ST_RD;
                    end
                    else if (start_reg + k_reg >= qlen_reg)
                    begin
                        // Ran off the end of the query: this entry does not occur.
                        if (int'(ent_reg) == NUM_FILTERS - 1)
                        begin
                            state_reg <= ST_IDLE;
                            emit = 1'b1;
                            out_reg <= '{fsft_pkg::KIND_QUERY, 1'b0, 32'd0};
                        end
                        else
                        begin
                            ent_reg   <= ent_reg + SW'(1);
                            state_reg <= ST_ENTRY;
                        end
                    end
                    else
                    begin
                        start_reg <= start_reg + CW'(1);
                        k_reg     <= '0;
                        state_reg <= ST_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // Output register: a new result replaces one leaving in this cycle.
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg) else $error("result lost");
    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !q_ready) else $error("take while searching");
    a_hit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ENTRY && hit_reg && out_free |=> state_reg == ST_IDLE)
        else $error("search did not stop on hit");
endmodule
